@@ rtl/vafc_pkg.sv @@
// ----------------------------------------------------------------------------
// vafc_pkg: shared types and constants
// Source format codes, scale factors and the per-lane result record used by
// the vertex attribute format converter.
// ----------------------------------------------------------------------------
package vafc_pkg;

    localparam logic [2:0] FMT_F32    = 3'd0;
    localparam logic [2:0] FMT_F16    = 3'd1;
    localparam logic [2:0] FMT_S8     = 3'd2;
    localparam logic [2:0] FMT_U8     = 3'd3;
    localparam logic [2:0] FMT_ABSENT = 3'd4;

    localparam logic MODE_NORMAL = 1'b0;
    localparam logic MODE_COLOR  = 1'b1;

    localparam logic [8:0] NORM_SCALE = 9'd511;
    localparam logic [8:0] CLR_SCALE  = 9'd255;

    localparam int NUM_LANES = 4;
    localparam int NORM_W    = 10;
    localparam int CLR_W     = 8;

    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic [CLR_W-1:0]  color;
    } lane_result_t;

endpackage

@@ rtl/vafc_if.sv @@
// ----------------------------------------------------------------------------
// vafc_if: request and result channels of the vertex attribute format converter
// One interface for incoming vertex attribute requests and one for the
// converted results, each with valid/ready flow control.
// ----------------------------------------------------------------------------
interface vafc_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [2:0]  format;
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
    logic        last_vertex;

    modport source (
        output valid, mode, format, comp_x, comp_y, comp_z, comp_w, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, mode, format, comp_x, comp_y, comp_z, comp_w, last_vertex,
        output ready
    );
endinterface

interface vafc_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] normal_word;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_out;

    modport source (
        output valid, normal_word, red, green, blue, alpha, last_out,
        input  ready
    );
    modport sink (
        input  valid, normal_word, red, green, blue, alpha, last_out,
        output ready
    );
endinterface

@@ rtl/vafc_lane.sv @@
// ----------------------------------------------------------------------------
// vafc_lane: one component conversion lane
// Decodes a raw component, forms the exact scaled product in a first
// register stage, then shifts, clamps and formats it for normal and color.
// ----------------------------------------------------------------------------
module vafc_lane (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  mode,
    input  logic [2:0]            format,
    input  logic [31:0]           raw,
    output vafc_pkg::lane_result_t result
);

    logic [2:0]  fmt_reg,  fmt_next;
    logic [7:0]  byte_reg, byte_next;
    logic [32:0] prod_reg, prod_next;
    logic [7:0]  sh_reg,   sh_next;
    logic        sat_reg,  sat_next;
    logic        zero_reg, zero_next;
    logic        sign_reg, sign_next;

    logic [7:0]  ex;
    logic [22:0] fr;
    logic [23:0] mant;
    logic        ex_max;
    logic [8:0]  scale;

    // Decode the float fields and the shift that turns the integer product
    // into the truncated real product.
    always_comb
    begin
        ex        = 8'd0;
        fr        = 23'd0;
        mant      = 24'd0;
        ex_max    = 1'b0;
        sign_next = 1'b0;
        sh_next   = 8'd0;
        sat_next  = 1'b0;
        zero_next = 1'b0;
        scale     = (mode == vafc_pkg::MODE_COLOR) ? vafc_pkg::CLR_SCALE
                                                   : vafc_pkg::NORM_SCALE;
        if (format == vafc_pkg::FMT_F16)
        begin
            sign_next = raw[15];
            ex        = {3'd0, raw[14:10]};
            fr        = {13'd0, raw[9:0]};
            ex_max    = (raw[14:10] == 5'h1F);
            mant      = (ex == 8'd0) ? {1'b0, fr} : {13'd0, 1'b1, raw[9:0]};
            sh_next   = (ex == 8'd0) ? 8'd24 : 8'd25 - ex;
            sat_next  = (ex >= 8'd25);
        end
        else
        begin
            sign_next = raw[31];
            ex        = raw[30:23];
            fr        = raw[22:0];
            ex_max    = (raw[30:23] == 8'hFF);
            mant      = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
            sh_next   = (ex == 8'd0) ? 8'd149 : 8'd150 - ex;
            sat_next  = (ex >= 8'd150);
        end
        // NaN and zero collapse to zero; infinity saturates.
        if (ex_max && (fr != 23'd0))
        begin
            zero_next = 1'b1;
        end
        else if (mant == 24'd0)
        begin
            zero_next = 1'b1;
        end
        prod_next = {9'd0, mant} * {24'd0, scale};
        fmt_next  = format;
        byte_next = raw[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fmt_reg  <= fmt_next;
            byte_reg <= byte_next;
            prod_reg <= prod_next;
            sh_reg   <= sh_next;
            sat_reg  <= sat_next;
            zero_reg <= zero_next;
            sign_reg <= sign_next;
        end
    end

    logic [32:0] mag;
    logic [9:0]  norm_f;
    logic [7:0]  clr_f;
    logic        big;

    always_comb
    begin
        mag = 33'd0;
        if (!zero_reg && !sat_reg && (sh_reg < 8'd33))
        begin
            mag = prod_reg >> sh_reg[5:0];
        end
        big = sat_reg && !zero_reg;

        if (sign_reg)
        begin
            norm_f = (big || (mag >= 33'd512)) ? 10'h200 : 10'(-mag[9:0]);
            clr_f  = 8'd0;
        end
        else
        begin
            norm_f = (big || (mag > 33'd511)) ? 10'd511 : mag[9:0];
            clr_f  = (big || (mag > 33'd255)) ? 8'd255 : mag[7:0];
        end

        case (fmt_reg)
            vafc_pkg::FMT_F32, vafc_pkg::FMT_F16:
            begin
                result.norm  = norm_f;
                result.color = clr_f;
            end
            vafc_pkg::FMT_S8:
            begin
                // The arithmetic right shift of a negative byte sets every
                // bit above the low two.
                result.norm  = byte_reg[7] ? {8'hFF, byte_reg[7:6]}
                                           : {byte_reg, byte_reg[7:6]};
                result.color = byte_reg[7] ? 8'd0 : {byte_reg[6:0], 1'b0};
            end
            vafc_pkg::FMT_U8:
            begin
                result.norm  = {1'b0, byte_reg, byte_reg[7]};
                result.color = byte_reg;
            end
            default:
            begin
                result.norm  = 10'd0;
                result.color = 8'd255;
            end
        endcase
    end

endmodule

@@ rtl/vafc_merge.sv @@
// ----------------------------------------------------------------------------
// vafc_merge: lane merge and output register
// Packs the lane results into the normal word or the four color bytes,
// according to the attribute kind, and holds the finished result.
// ----------------------------------------------------------------------------
module vafc_merge (
    input  logic                   clk,
    input  logic                   en,
    input  logic                   mode,
    input  logic                   last_vertex,
    input  vafc_pkg::lane_result_t lanes [vafc_pkg::NUM_LANES],
    output logic [29:0]            normal_word,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    output logic [7:0]             alpha,
    output logic                   last_out
);

    logic [29:0] normal_reg, normal_next;
    logic [31:0] color_reg,  color_next;
    logic        last_reg;

    always_comb
    begin
        if (mode == vafc_pkg::MODE_COLOR)
        begin
            normal_next = 30'd0;
            color_next  = {lanes[3].color, lanes[2].color, lanes[1].color,
                           lanes[0].color};
        end
        else
        begin
            normal_next = {lanes[2].norm, lanes[1].norm, lanes[0].norm};
            color_next  = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            normal_reg <= normal_next;
            color_reg  <= color_next;
            last_reg   <= last_vertex;
        end
    end

    assign normal_word = normal_reg;
    assign red         = color_reg[7:0];
    assign green       = color_reg[15:8];
    assign blue        = color_reg[23:16];
    assign alpha       = color_reg[31:24];
    assign last_out    = last_reg;

endmodule

@@ rtl/vertex_attribute_format_converter.sv @@
// ----------------------------------------------------------------------------
// vertex_attribute_format_converter: normal and color attribute converter
//
//   channel | direction | contents
//   --------+-----------+-----------------------------------------------
//   src     | in        | mode, format, comp_x..comp_w, last_vertex
//   dst     | out       | normal_word, red, green, blue, alpha, last_out
//
// One request is taken per cycle while dst does not stall; each result reaches
// dst through the lane registers and the merge output register, and waits
// while a result ahead of it stalls. Stage one decodes and multiplies in four
// lanes, stage two shifts, clamps and merges into the output register.
// Reset clears only the two stage valid flags.
// A stall on dst holds both stages; src keeps flowing while stage one is free.
// ----------------------------------------------------------------------------
module vertex_attribute_format_converter (
    input  logic            clk,
    input  logic            rst_n,
    vafc_in_if.sink         src,
    vafc_out_if.source      dst
);

    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic mode_reg;
    logic last_reg;
    logic adv_a;
    logic adv_b;

    vafc_pkg::lane_result_t lanes [vafc_pkg::NUM_LANES];
    logic [31:0] raw [vafc_pkg::NUM_LANES];

    assign adv_b     = va_reg && (!vb_reg || dst.ready);
    assign src.ready = !va_reg || adv_b;
    assign adv_a     = src.valid && src.ready;

    always_comb
    begin
        va_next = va_reg;
        vb_next = vb_reg;
        if (adv_a)
        begin
            va_next = 1'b1;
        end
        else if (adv_b)
        begin
            va_next = 1'b0;
        end
        if (adv_b)
        begin
            vb_next = 1'b1;
        end
        else if (dst.ready)
        begin
            vb_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            mode_reg <= src.mode;
            last_reg <= src.last_vertex;
        end
    end

    assign raw[0] = src.comp_x;
    assign raw[1] = src.comp_y;
    assign raw[2] = src.comp_z;
    assign raw[3] = src.comp_w;

    for (genvar i = 0; i < vafc_pkg::NUM_LANES; i++)
    begin : g_lane
        vafc_lane u_lane (
            .clk    (clk),
            .en     (adv_a),
            .mode   (src.mode),
            .format (src.format),
            .raw    (raw[i]),
            .result (lanes[i])
        );
    end

    vafc_merge u_merge (
        .clk         (clk),
        .en          (adv_b),
        .mode        (mode_reg),
        .last_vertex (last_reg),
        .lanes       (lanes),
        .normal_word (dst.normal_word),
        .red         (dst.red),
        .green       (dst.green),
        .blue        (dst.blue),
        .alpha       (dst.alpha),
        .last_out    (dst.last_out)
    );

    assign dst.valid = vb_reg;

    // An empty first stage always takes a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !va_reg |-> src.ready)
        else $error("src not ready while stage one is empty");

    // A result of one kind never carries fields of the other kind.
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid |-> (dst.normal_word == 30'd0) ||
                      ({dst.red, dst.green, dst.blue, dst.alpha} == 32'd0))
        else $error("normal and color fields both nonzero");

    // A pending stage-one request follows a taken result without a bubble.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && dst.ready && va_reg) |=> dst.valid)
        else $error("bubble inserted behind a taken result");

    // An accepted request moves on at the next edge unless the result ahead
    // of it is stalled.
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv_a |=> (adv_b || (dst.valid && !dst.ready)))
        else $error("accepted request did not advance");

endmodule
